// ===== rtl/core/tdrm_pkg.sv =====
// Shared constants and types for the transmit descriptor ring manager.
`default_nettype none

package tdrm_pkg;

    // Field widths fixed by the descriptor format.
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int ADDR_W    = 64;
    localparam int WORD_W    = 32;
    localparam int HALF_W    = 16;
    localparam int LG_W      = 4;
    localparam int CFG_IDX_W = 1;

    // Ring geometry limits.
    localparam int MAX_RING     = 4096;
    localparam int MAX_RING_LG  = $clog2(MAX_RING + 1) - 1;
    localparam int RING_LG_HI   = 12;
    localparam int RING_LG_LO   = 1;
    localparam int FLAG_DEPTH   = 4096;
    localparam int PAYLEN_SHIFT = 14;

    // Reset values of the configuration registers.
    localparam logic [LG_W-1:0]   RING_LG_RESET   = 4'd9;
    localparam logic [WORD_W-1:0] CMD_FLAGS_RESET = '0;

    // Operation carried by an input transaction.
    typedef enum logic [1:0] {
        MODE_POST      = 2'd0,
        MODE_CLEAN     = 2'd1,
        MODE_WRITEBACK = 2'd2,
        MODE_NONE      = 2'd3
    } mode_t;

    // Outcome reported with each result transaction.
    typedef enum logic [2:0] {
        RC_POSTED    = 3'd0,
        RC_DROPPED   = 3'd1,
        RC_CLEANED   = 3'd2,
        RC_TOO_FEW   = 3'd3,
        RC_NOT_DONE  = 3'd4,
        RC_WB_NOTED  = 3'd5
    } result_code_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_SIZE_LOG2 = 1'b0,
        REG_COMMAND_FLAGS  = 1'b1
    } cfg_reg_t;

endpackage : tdrm_pkg

`default_nettype wire

// ===== rtl/core/tx_descriptor_ring_manager_top.sv =====
// Top level of the transmit descriptor ring manager: pointers, flag store and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   post a buffer, clean a batch, or note a device writeback. Mode 3 is taken
//   and discarded without a result. Every other transaction yields exactly one
//   result transaction on out_valid/out_ready, in order.
//   Path: an accepted transaction moves to the working stage, then to the
//   output register. Throughput is one transaction per cycle unless stalled:
//   the done-flag store is read once and written once per cycle, and the head
//   and tail pointers are forwarded from the commit stage to the next item.
//   Reset: head and tail return to zero and the configuration registers take
//   their defaults. The done-flag RAM is then cleared by a sweep, one entry
//   per cycle, during which in_ready stays low. Register writes on the cfg
//   port are taken at any time.
//   Stall: when out_ready is low the result stays in the output register; one
//   more transaction may sit in the working stage, after which in_ready drops.
`default_nettype none

module tx_descriptor_ring_manager_top
    import tdrm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    // Input channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           mode,
    input  wire logic [ADDR_W-1:0]    buffer_base,
    input  wire logic [HALF_W-1:0]    payload_offset,
    input  wire logic [HALF_W-1:0]    packet_length,
    input  wire logic [CNT_W-1:0]     clean_count,
    input  wire logic [IDX_W-1:0]     done_slot,
    // Result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                result_code,
    output logic [IDX_W-1:0]          descriptor_index,
    output logic [ADDR_W-1:0]         buffer_address,
    output logic [WORD_W-1:0]         command_length,
    output logic [WORD_W-1:0]         offload_status,
    output logic [CNT_W-1:0]          freed_count,
    output logic [IDX_W-1:0]          tail_now,
    output logic [IDX_W-1:0]          head_now
);

    localparam int FLAG_AW = $clog2(FLAG_DEPTH);

    // Working stage contents, decoded at accept time.
    typedef struct packed {
        result_code_t      code;
        logic              pend;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] cmd;
        logic [WORD_W-1:0] olinfo;
        logic [CNT_W-1:0]  cnt;
        logic              tail_upd;
        logic [IDX_W-1:0]  tail_new;
        logic [IDX_W-1:0]  head_new;
        logic              we;
        logic [FLAG_AW-1:0] waddr;
        logic              wdata;
    } stage_t;

    logic [LG_W-1:0]   ring_size_log2_reg;
    logic [WORD_W-1:0] command_flags_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;

    logic               clr_active_reg;
    logic [FLAG_AW-1:0] clr_addr_reg;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    stage_t s1_reg;
    stage_t s1_next;
    logic   s1_advance;
    logic   byp_valid_reg;
    logic   byp_data_reg;

    logic               accept;
    logic               load;
    logic [IDX_W-1:0]   mask;
    logic [LG_W-1:0]    lg_eff;
    logic [FLAG_AW-1:0] rd_addr;

    logic               ram_we;
    logic [FLAG_AW-1:0] ram_waddr;
    logic               ram_wdata;
    logic               ram_rdata;
    logic               flag;
    logic               cleaned;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_code_t         res_code_reg;
    result_code_t         res_code_next;
    logic [IDX_W-1:0]     res_idx_reg;
    logic [IDX_W-1:0]     res_idx_next;
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [WORD_W-1:0]    res_cmd_reg;
    logic [WORD_W-1:0]    res_olinfo_reg;
    logic [CNT_W-1:0]     res_freed_reg;
    logic [CNT_W-1:0]     res_freed_next;
    logic [IDX_W-1:0]     res_tail_reg;
    logic [IDX_W-1:0]     res_head_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_log2_reg <= RING_LG_RESET;
            command_flags_reg  <= CMD_FLAGS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RING_SIZE_LOG2: ring_size_log2_reg <= cfg_data[LG_W-1:0];
                REG_COMMAND_FLAGS:  command_flags_reg  <= cfg_data;
            endcase
        end
    end

    // Effective ring size: clamp to the legal range, then to the largest ring supported.
    always_comb
    begin
        lg_eff = ring_size_log2_reg;
        if (lg_eff < LG_W'(RING_LG_LO))
        begin
            lg_eff = LG_W'(RING_LG_LO);
        end
        if (lg_eff > LG_W'(RING_LG_HI))
        begin
            lg_eff = LG_W'(RING_LG_HI);
        end
        if (lg_eff > LG_W'(MAX_RING_LG))
        begin
            lg_eff = LG_W'(MAX_RING_LG);
        end
        mask = IDX_W'(((IDX_W + 1)'(1) << lg_eff) - (IDX_W + 1)'(1));
    end

    // Handshake and stage movement.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !clr_active_reg && (!s1_valid_reg || s1_advance);
    assign accept     = in_valid && in_ready;
    assign load       = accept && (mode_t'(mode) != MODE_NONE);

    // Commit of the working stage: the flag read resolves a pending clean.
    assign flag    = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign cleaned = s1_reg.pend && flag;

    always_comb
    begin
        head_next = (s1_advance && cleaned) ? s1_reg.head_new : head_reg;
        tail_next = (s1_advance && s1_reg.tail_upd) ? s1_reg.tail_new : tail_reg;
        if (s1_reg.pend)
        begin
            res_code_next  = cleaned ? RC_CLEANED : RC_NOT_DONE;
            res_idx_next   = cleaned ? s1_reg.idx : '0;
            res_freed_next = cleaned ? s1_reg.cnt : '0;
        end
        else
        begin
            res_code_next  = s1_reg.code;
            res_idx_next   = s1_reg.idx;
            res_freed_next = '0;
        end
    end

    // Decode of the incoming transaction against the forwarded pointers.
    always_comb
    begin
        logic [IDX_W-1:0] t;
        logic [IDX_W-1:0] h;
        logic [IDX_W-1:0] nxt;
        logic [IDX_W-1:0] outstanding;
        logic [CNT_W-1:0] sum;
        logic [IDX_W-1:0] last;

        t           = tail_next & mask;
        h           = head_next & mask;
        nxt         = (t + IDX_W'(1)) & mask;
        outstanding = (t - h) & mask;
        sum         = {1'b0, h} + clean_count - CNT_W'(1);
        last        = sum[IDX_W-1:0] & mask;
        rd_addr     = FLAG_AW'(last);

        s1_next      = '0;
        s1_next.code = RC_POSTED;
        unique case (mode_t'(mode))
            MODE_POST:
            begin
                if (nxt == h)
                begin
                    s1_next.code = RC_DROPPED;
                end
                else
                begin
                    s1_next.idx      = t;
                    s1_next.addr     = buffer_base
                                       + {{(ADDR_W - HALF_W){1'b0}}, payload_offset};
                    s1_next.cmd      = command_flags_reg
                                       | {{(WORD_W - HALF_W){1'b0}}, packet_length};
                    s1_next.olinfo   = {{(WORD_W - HALF_W){1'b0}}, packet_length}
                                       << PAYLEN_SHIFT;
                    s1_next.tail_upd = 1'b1;
                    s1_next.tail_new = nxt;
                    s1_next.we       = 1'b1;
                    s1_next.waddr    = FLAG_AW'(t);
                    s1_next.wdata    = 1'b0;
                end
            end
            MODE_CLEAN:
            begin
                if (clean_count == '0 || clean_count > {1'b0, outstanding})
                begin
                    s1_next.code = RC_TOO_FEW;
                end
                else
                begin
                    s1_next.pend     = 1'b1;
                    s1_next.idx      = h;
                    s1_next.cnt      = clean_count;
                    s1_next.head_new = (last + IDX_W'(1)) & mask;
                end
            end
            MODE_WRITEBACK:
            begin
                s1_next.code  = RC_WB_NOTED;
                s1_next.idx   = done_slot;
                s1_next.we    = 1'b1;
                s1_next.waddr = FLAG_AW'(done_slot);
                s1_next.wdata = 1'b1;
            end
            MODE_NONE:
            begin
                s1_next.code = RC_POSTED;
            end
        endcase
    end

    assign s1_valid_next = load ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    // Flag RAM write port: clearing sweep after reset, else the committing item.
    assign ram_we    = clr_active_reg || (s1_advance && s1_reg.we);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_reg.waddr;
    assign ram_wdata = clr_active_reg ? 1'b0 : s1_reg.wdata;

    tdrm_ram #(
        .WIDTH (1),
        .DEPTH (FLAG_DEPTH)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (load),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Control state: pointers, clearing sweep and stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg       <= '0;
            head_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byp_valid_reg  <= 1'b0;
        end
        else
        begin
            tail_reg      <= tail_next;
            head_reg      <= head_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + FLAG_AW'(1);
                if (clr_addr_reg == {FLAG_AW{1'b1}})
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (load)
            begin
                byp_valid_reg <= ram_we && (ram_waddr == rd_addr);
            end
        end
    end

    assign out_valid_next = s1_advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Stage and result payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg       <= s1_next;
            byp_data_reg <= ram_wdata;
        end
        if (s1_advance)
        begin
            res_code_reg   <= res_code_next;
            res_idx_reg    <= res_idx_next;
            res_addr_reg   <= s1_reg.addr;
            res_cmd_reg    <= s1_reg.cmd;
            res_olinfo_reg <= s1_reg.olinfo;
            res_freed_reg  <= res_freed_next;
            res_tail_reg   <= tail_next;
            res_head_reg   <= head_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_code      = res_code_reg;
    assign descriptor_index = res_idx_reg;
    assign buffer_address   = res_addr_reg;
    assign command_length   = res_cmd_reg;
    assign offload_status   = res_olinfo_reg;
    assign freed_count      = res_freed_reg;
    assign tail_now         = res_tail_reg;
    assign head_now         = res_head_reg;

endmodule : tx_descriptor_ring_manager_top

`default_nettype wire

// ===== rtl/core/tdrm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tdrm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port returns the contents before a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : tdrm_ram

`default_nettype wire

// ===== rtl/core/tdrm_checker.sv =====
// Port-level checker for the transmit descriptor ring manager, bound to the top level.
`default_nettype none

module tdrm_checker
    import tdrm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [2:0]        result_code,
    input wire logic [IDX_W-1:0]  descriptor_index,
    input wire logic [ADDR_W-1:0] buffer_address,
    input wire logic [WORD_W-1:0] command_length,
    input wire logic [WORD_W-1:0] offload_status,
    input wire logic [CNT_W-1:0]  freed_count,
    input wire logic [IDX_W-1:0]  tail_now
);

    localparam logic [WORD_W-1:0] LOW_MASK = WORD_W'((64'd1 << PAYLEN_SHIFT) - 64'd1);

    // A stalled result transaction holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_code)
            && $stable(descriptor_index) && $stable(freed_count))
        else $error("result changed while stalled");

    // Only a posted descriptor carries address and command words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code != RC_POSTED |->
            buffer_address == '0 && command_length == '0 && offload_status == '0)
        else $error("descriptor words on a result that did not post");

    // A released count appears exactly on a successful clean.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_code == RC_CLEANED) == (freed_count != '0)))
        else $error("freed count does not match clean outcome");

    // A post moves the tail off the written slot, and the length field sits above the shift.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code == RC_POSTED |->
            descriptor_index != tail_now && (offload_status & LOW_MASK) == '0)
        else $error("post result inconsistent");

endmodule : tdrm_checker

bind tx_descriptor_ring_manager_top tdrm_checker u_tdrm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_code      (result_code),
    .descriptor_index (descriptor_index),
    .buffer_address   (buffer_address),
    .command_length   (command_length),
    .offload_status   (offload_status),
    .freed_count      (freed_count),
    .tail_now         (tail_now)
);

`default_nettype wire

// ===== verif/tb_tx_descriptor_ring_manager_top.sv =====
// Testbench for the transmit descriptor ring manager: directed and random traffic, checked by a scoreboard.
module tb_tx_descriptor_ring_manager_top;
    import tdrm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AT     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int NUM_PHASES      = 7;

    // One input transaction.
    typedef struct {
        mode_t              op;
        logic [ADDR_W-1:0]  base;
        logic [HALF_W-1:0]  offset;
        logic [HALF_W-1:0]  length;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   slot;
    } ring_op_t;

    // One result transaction.
    typedef struct {
        result_code_t       code;
        logic [IDX_W-1:0]   index;
        logic [ADDR_W-1:0]  address;
        logic [WORD_W-1:0]  cmd_len;
        logic [WORD_W-1:0]  offload;
        logic [CNT_W-1:0]   freed;
        logic [IDX_W-1:0]   tail;
        logic [IDX_W-1:0]   head;
    } ring_result_t;

    // Ring predictor and in-order store of expected results.
    class ring_scoreboard;
        logic [LG_W-1:0]   size_lg;
        logic [WORD_W-1:0] cmd_flags;
        logic [IDX_W-1:0]  tail_ptr;
        logic [IDX_W-1:0]  head_ptr;
        bit                done_flag [FLAG_DEPTH];
        ring_result_t      expected_results [$];
        int unsigned       errors;
        int unsigned       results_seen;

        function new();
            size_lg      = RING_LG_RESET;
            cmd_flags    = CMD_FLAGS_RESET;
            tail_ptr     = '0;
            head_ptr     = '0;
            errors       = 0;
            results_seen = 0;
            foreach (done_flag[i])
            begin
                done_flag[i] = 1'b0;
            end
        endfunction

        function void write_reg(cfg_reg_t idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_RING_SIZE_LOG2: size_lg = data[LG_W-1:0];
                REG_COMMAND_FLAGS:  cmd_flags = data;
                default: ;
            endcase
        endfunction

        // Descriptors in use: the log2 setting is clamped, then capped at the ring limit.
        function int unsigned ring_len();
            int unsigned lg;
            int unsigned n;
            lg = size_lg;
            if (lg < RING_LG_LO)
                lg = RING_LG_LO;
            if (lg > RING_LG_HI)
                lg = RING_LG_HI;
            n = 1 << lg;
            while (n > 2 && n > MAX_RING)
                n = n >> 1;
            return n;
        endfunction

        function logic [IDX_W-1:0] index_mask();
            return IDX_W'(ring_len() - 1);
        endfunction

        function logic [IDX_W-1:0] outstanding();
            logic [IDX_W-1:0] mask;
            mask = index_mask();
            return ((tail_ptr & mask) - (head_ptr & mask)) & mask;
        endfunction

        // Update the ring state for an accepted transaction and queue its result.
        function void note_input(ring_op_t it);
            ring_result_t     r;
            logic [IDX_W-1:0] mask;
            logic [IDX_W-1:0] t;
            logic [IDX_W-1:0] h;
            logic [IDX_W-1:0] nxt;
            logic [IDX_W-1:0] last;
            logic [WORD_W-1:0] wide_len;
            if (it.op == MODE_NONE)
                return;
            mask      = index_mask();
            t         = tail_ptr & mask;
            h         = head_ptr & mask;
            r.code    = RC_POSTED;
            r.index   = '0;
            r.address = '0;
            r.cmd_len = '0;
            r.offload = '0;
            r.freed   = '0;
            case (it.op)
                MODE_POST:
                begin
                    nxt = (t + 1'b1) & mask;
                    if (nxt == h)
                    begin
                        r.code = RC_DROPPED;
                    end
                    else
                    begin
                        r.index      = t;
                        done_flag[t] = 1'b0;
                        r.address    = it.base + ADDR_W'(it.offset);
                        r.cmd_len    = cmd_flags | WORD_W'(it.length);
                        wide_len     = WORD_W'(it.length);
                        r.offload    = wide_len << PAYLEN_SHIFT;
                        tail_ptr     = nxt;
                    end
                end
                MODE_CLEAN:
                begin
                    if (it.count == 0 || it.count > CNT_W'(outstanding()))
                    begin
                        r.code = RC_TOO_FEW;
                    end
                    else
                    begin
                        last = IDX_W'(h + it.count - 1) & mask;
                        if (!done_flag[last])
                        begin
                            r.code = RC_NOT_DONE;
                        end
                        else
                        begin
                            r.code   = RC_CLEANED;
                            r.index  = h;
                            r.freed  = it.count;
                            head_ptr = (last + 1'b1) & mask;
                        end
                    end
                end
                default:
                begin
                    done_flag[it.slot] = 1'b1;
                    r.code  = RC_WB_NOTED;
                    r.index = it.slot;
                end
            endcase
            r.tail = tail_ptr;
            r.head = head_ptr;
            expected_results.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Compare a result transaction with the oldest expectation.
        function void check_result(ring_result_t got);
            ring_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual code %0d",
                         $time, got.code);
                return;
            end
            want = expected_results.pop_front();
            compare("result_code", want.code, got.code);
            compare("descriptor_index", want.index, got.index);
            compare("buffer_address", want.address, got.address);
            compare("command_length", want.cmd_len, got.cmd_len);
            compare("offload_status", want.offload, got.offload);
            compare("freed_count", want.freed, got.freed);
            compare("tail_now", want.tail, got.tail);
            compare("head_now", want.head, got.head);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           mode;
    logic [ADDR_W-1:0]    buffer_base;
    logic [HALF_W-1:0]    payload_offset;
    logic [HALF_W-1:0]    packet_length;
    logic [CNT_W-1:0]     clean_count;
    logic [IDX_W-1:0]     done_slot;
    logic                 out_valid;
    logic                 out_ready;
    logic [2:0]           result_code;
    logic [IDX_W-1:0]     descriptor_index;
    logic [ADDR_W-1:0]    buffer_address;
    logic [WORD_W-1:0]    command_length;
    logic [WORD_W-1:0]    offload_status;
    logic [CNT_W-1:0]     freed_count;
    logic [IDX_W-1:0]     tail_now;
    logic [IDX_W-1:0]     head_now;

    ring_scoreboard sb;
    bit             tx_idle_on;
    bit             rx_idle_on;

    tx_descriptor_ring_manager_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .buffer_base      (buffer_base),
        .payload_offset   (payload_offset),
        .packet_length    (packet_length),
        .clean_count      (clean_count),
        .done_slot        (done_slot),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_code      (result_code),
        .descriptor_index (descriptor_index),
        .buffer_address   (buffer_address),
        .command_length   (command_length),
        .offload_status   (offload_status),
        .freed_count      (freed_count),
        .tail_now         (tail_now),
        .head_now         (head_now)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic ring_op_t op_of(mode_t m, logic [ADDR_W-1:0] base,
                                       logic [HALF_W-1:0] offset, logic [HALF_W-1:0] length,
                                       logic [CNT_W-1:0] count, logic [IDX_W-1:0] slot);
        ring_op_t it;
        it.op     = m;
        it.base   = base;
        it.offset = offset;
        it.length = length;
        it.count  = count;
        it.slot   = slot;
        return it;
    endfunction

    // Mostly well-formed ring traffic built from the current ring state, with some noise.
    function automatic ring_op_t random_op();
        ring_op_t         it;
        logic [IDX_W-1:0] mask;
        logic [IDX_W-1:0] h;
        logic [IDX_W-1:0] in_flight;
        int unsigned      pick;
        int unsigned      cnt;
        it.base   = {$urandom, $urandom};
        it.offset = HALF_W'($urandom);
        it.length = HALF_W'($urandom);
        it.count  = CNT_W'($urandom_range(0, MAX_RING));
        it.slot   = IDX_W'($urandom);
        it.op     = MODE_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            it.op = mode_t'($urandom_range(0, 3));
            return it;
        end
        mask      = sb.index_mask();
        h         = sb.head_ptr & mask;
        in_flight = sb.outstanding();
        pick      = $urandom_range(0, 99);
        if (pick < 40 || (in_flight == 0 && pick < 70))
        begin
            it.op = MODE_POST;
        end
        else if (pick < 70)
        begin
            // The device reports a descriptor that is still in flight.
            it.op   = MODE_WRITEBACK;
            it.slot = (h + IDX_W'($urandom_range(0, in_flight - 1))) & mask;
        end
        else
        begin
            it.op = MODE_CLEAN;
            if (in_flight == 0)
            begin
                cnt = $urandom_range(0, 1);
            end
            else
            begin
                cnt = $urandom_range(1, in_flight);
                // Usually shrink the batch so that its last descriptor is done.
                if ($urandom_range(0, 99) < 60)
                begin
                    for (int c = cnt; c >= 1; c--)
                    begin
                        if (sb.done_flag[(h + c - 1) & mask])
                        begin
                            cnt = c;
                            break;
                        end
                    end
                end
            end
            it.count = CNT_W'(cnt);
        end
        return it;
    endfunction

    // Offer one transaction, optionally after random idle cycles, and wait for acceptance.
    task automatic send_op(ring_op_t it);
        while (tx_idle_on && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= it.op;
        buffer_base    <= it.base;
        payload_offset <= it.offset;
        packet_length  <= it.length;
        clean_count    <= it.count;
        done_slot      <= it.slot;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
    endtask

    // Write both configuration registers; only called while the block is idle.
    task automatic program_ring(logic [LG_W-1:0] lg, logic [WORD_W-1:0] flags);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RING_SIZE_LOG2;
        cfg_data  <= WORD_W'(lg);
        @(posedge clk);
        sb.write_reg(REG_RING_SIZE_LOG2, WORD_W'(lg));
        cfg_index <= REG_COMMAND_FLAGS;
        cfg_data  <= flags;
        @(posedge clk);
        sb.write_reg(REG_COMMAND_FLAGS, flags);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: checks accepted results and applies backpressure, including one long hold-off.
    initial
    begin
        ring_result_t got;
        int unsigned  hold_left;
        bit           hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.code    = result_code_t'(result_code);
                got.index   = descriptor_index;
                got.address = buffer_address;
                got.cmd_len = command_length;
                got.offload = offload_status;
                got.freed   = freed_count;
                got.tail    = tail_now;
                got.head    = head_now;
                sb.check_result(got);
            end
            if (!hold_done && sb.results_seen >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 35);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Main sequence: reset, directed cases, then random phases over several ring settings.
    initial
    begin
        logic [LG_W-1:0]   phase_lg [NUM_PHASES];
        int unsigned       phase_items [NUM_PHASES];
        logic [WORD_W-1:0] flags;
        phase_lg    = '{4'd2, 4'd4, 4'd13, 4'd3, 4'd12, 4'd0, 4'd6};
        phase_items = '{150, 200, 150, 150, 100, 150, 150};
        sb             = new();
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_RING_SIZE_LOG2;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        mode           <= MODE_POST;
        buffer_base    <= '0;
        payload_offset <= '0;
        packet_length  <= '0;
        clean_count    <= '0;
        done_slot      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest ring: one usable slot, full drop, refused and incomplete cleans.
        program_ring(4'd1, 32'h0000_0000);
        send_op(op_of(MODE_POST, 64'h0, 16'h0, 16'h0, 13'd0, 12'd0));
        send_op(op_of(MODE_POST, 64'h1234_5678_9abc_def0, 16'h0040, 16'h05ea, 13'd0, 12'd0));
        send_op(op_of(MODE_CLEAN, 64'h0, 16'h0, 16'h0, 13'd0, 12'd0));
        send_op(op_of(MODE_CLEAN, 64'h0, 16'h0, 16'h0, 13'd2, 12'd0));
        send_op(op_of(MODE_CLEAN, 64'h0, 16'h0, 16'h0, 13'd1, 12'd0));
        send_op(op_of(MODE_WRITEBACK, 64'h0, 16'h0, 16'h0, 13'd0, 12'd0));
        send_op(op_of(MODE_CLEAN, 64'h0, 16'h0, 16'h0, 13'd1, 12'd0));
        send_op(op_of(MODE_WRITEBACK, 64'h0, 16'h0, 16'h0, 13'd0, 12'hfff));
        send_op(op_of(MODE_NONE, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff,
                      13'h1fff, 12'hfff));
        send_op(op_of(MODE_POST, 64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff, 13'd0, 12'd0));
        drain_results();

        // Largest ring with the pointers left from the small one; all command bits set.
        program_ring(4'd15, 32'hffff_ffff);
        send_op(op_of(MODE_POST, 64'h0, 16'h0, 16'h0, 13'd0, 12'd0));
        send_op(op_of(MODE_CLEAN, 64'h0, 16'h0, 16'h0, 13'd4096, 12'd0));
        send_op(op_of(MODE_CLEAN, 64'h0, 16'h0, 16'h0, 13'd4095, 12'd0));
        send_op(op_of(MODE_POST, 64'h8000_0000_0000_0000, 16'h8000, 16'h8000, 13'd0, 12'd0));
        send_op(op_of(MODE_WRITEBACK, 64'h0, 16'h0, 16'h0, 13'd0, 12'd0));
        send_op(op_of(MODE_CLEAN, 64'h0, 16'h0, 16'h0, 13'd1, 12'd0));
        drain_results();

        // Size setting below the legal range falls back to two descriptors.
        program_ring(4'd0, 32'h8000_0001);
        send_op(op_of(MODE_POST, 64'h0000_0000_ffff_0000, 16'h0001, 16'h0001, 13'd0, 12'd0));
        send_op(op_of(MODE_POST, 64'h0, 16'h0, 16'h0, 13'd0, 12'd0));
        send_op(op_of(MODE_NONE, 64'h0, 16'h0, 16'h0, 13'd0, 12'd0));
        drain_results();

        // Random phases; one of them runs with no idling on either side.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 2)
                flags = 32'hffff_0000;
            else if (p == 6)
                flags = 32'h0000_0000;
            else
                flags = $urandom;
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2 && p != 6);
            program_ring(phase_lg[p], flags);
            repeat (phase_items[p]) send_op(random_op());
            drain_results();
        end

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
